/* rtl/core/avm_pkg.sv */
// Shared types, constants and codes for the averaging voltmeter core.
`default_nettype none

package avm_pkg;

    localparam int SAMPLES_PER_AVERAGE = 10;
    localparam int AVG_N = (SAMPLES_PER_AVERAGE < 1) ? 1 : SAMPLES_PER_AVERAGE;

    localparam int SUM_W   = 16;
    localparam int CNT_W   = 4;
    localparam int CNT_N_W = 5;
    localparam int CODE_W  = 12;
    localparam int HOLD_W  = 13;

    localparam logic [CNT_N_W-1:0] CNT_N = CNT_N_W'(AVG_N);

    localparam int DIV_SHIFT   = SUM_W;
    localparam int DIV_RECIP_W = SUM_W + 1;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
        DIV_RECIP_W'((longint'(1) << DIV_SHIFT) / AVG_N);
    localparam int DIV_PROD_W = SUM_W + DIV_RECIP_W;
    localparam int DIV_REM_W  = SUM_W + CNT_N_W;

    localparam logic [HOLD_W-1:0] MIN_RESET = HOLD_W'(4096);

    localparam int FULL_SCALE       = 4095;
    localparam int SCALE_HUNDREDTHS = 250;
    localparam int HUND_W           = 8;
    localparam int SCALED_W         = HOLD_W + HUND_W;
    localparam int H_FRAC           = 24;
    localparam int H_RECIP_W        = 20;
    localparam logic [H_RECIP_W-1:0] H_RECIP =
        H_RECIP_W'((longint'(SCALE_HUNDREDTHS) << H_FRAC) / FULL_SCALE);
    localparam int H_PROD_W = HOLD_W + H_RECIP_W;

    localparam int CENTS_PER_VOLT = 100;
    localparam int DIGIT_BASE     = 10;
    localparam int REM_W          = 7;
    localparam int TENTH_RECIP    = 205;
    localparam int TENTH_SHIFT    = 11;
    localparam int TENTH_PROD_W   = REM_W + 8;

    localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
    localparam logic [1:0] FUNC_RESET_HOLD = 2'd1;
    localparam logic [1:0] FUNC_TOGGLE     = 2'd2;

    localparam logic KIND_READING    = 1'b0;
    localparam logic KIND_HOLD_RESET = 1'b1;

    typedef enum logic [1:0] {
        SEL_CUR,
        SEL_MIN,
        SEL_MAX
    } conv_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_HOLD,
        ST_CONV_CUR,
        ST_CONV_MIN,
        ST_CONV_MAX,
        ST_CONV_WAIT,
        ST_EMIT
    } avm_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] sample;
    } meas_t;

    typedef struct packed {
        logic       kind;
        logic [1:0] cur_units;
        logic [3:0] cur_tenths;
        logic [3:0] cur_hundredths;
        logic [1:0] min_units;
        logic [3:0] min_tenths;
        logic [3:0] min_hundredths;
        logic [1:0] max_units;
        logic [3:0] max_tenths;
        logic [3:0] max_hundredths;
    } disp_t;

    typedef struct packed {
        logic [1:0] units;
        logic [3:0] tenths;
        logic [3:0] hundredths;
    } digits_t;

    typedef struct packed {
        logic      valid;
        conv_sel_t sel;
        digits_t   digits;
    } conv_out_t;

    typedef struct packed {
        logic      load_req;
        logic      exec;
        logic      div_mul;
        logic      div_fix;
        logic      hold_upd;
        logic      conv_start;
        conv_sel_t conv_sel;
        logic      emit_load;
    } avm_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       sampling_on;
        logic       avg_complete;
        logic       mean_repeat;
        logic       conv_done;
    } avm_status_t;

endpackage

`default_nettype wire

/* rtl/core/avm_digit_conv.sv */
// Five-stage pipeline that turns a converter code into volt, tenth and hundredth digits.
`default_nettype none

module avm_digit_conv (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire avm_pkg::conv_sel_t        sel,
    input  wire logic [avm_pkg::HOLD_W-1:0] code,
    output avm_pkg::conv_out_t             result
);
    import avm_pkg::*;

    logic                valid1_reg, valid2_reg, valid3_reg, valid4_reg, valid5_reg;
    conv_sel_t           sel1_reg, sel2_reg, sel3_reg, sel4_reg, sel5_reg;
    logic [H_PROD_W-1:0] hprod1_reg;
    logic [SCALED_W-1:0] scaled1_reg;
    logic [HUND_W-1:0]   hund2_reg;
    logic [1:0]          units3_reg, units4_reg;
    logic [REM_W-1:0]    rem3_reg, rem4_reg;
    logic [3:0]          tenths4_reg;
    digits_t             digits5_reg;

    logic [H_PROD_W-1:0]     hprod_next;
    logic [SCALED_W-1:0]     scaled_next;
    logic [HUND_W-1:0]       h_est;
    logic [SCALED_W-1:0]     h_back;
    logic [SCALED_W-1:0]     h_rem;
    logic [HUND_W-1:0]       hund_next;
    logic [1:0]              units_next;
    logic [HUND_W-1:0]       rem_wide;
    logic [TENTH_PROD_W-1:0] tenth_prod;
    logic [3:0]              tenths_next;
    logic [REM_W-1:0]        tenth_back;
    digits_t                 digits_next;

    always_comb
    begin
        hprod_next  = H_PROD_W'(code) * H_PROD_W'(H_RECIP);
        scaled_next = SCALED_W'(code) * SCALED_W'(SCALE_HUNDREDTHS);

        h_est  = hprod1_reg[H_FRAC +: HUND_W];
        h_back = SCALED_W'(h_est) * SCALED_W'(FULL_SCALE);
        h_rem  = scaled1_reg - h_back;
        if (h_rem >= SCALED_W'(FULL_SCALE))
        begin
            hund_next = h_est + HUND_W'(1);
        end
        else
        begin
            hund_next = h_est;
        end

        priority if (hund2_reg >= HUND_W'(2 * CENTS_PER_VOLT))
        begin
            units_next = 2'd2;
            rem_wide   = hund2_reg - HUND_W'(2 * CENTS_PER_VOLT);
        end
        else if (hund2_reg >= HUND_W'(CENTS_PER_VOLT))
        begin
            units_next = 2'd1;
            rem_wide   = hund2_reg - HUND_W'(CENTS_PER_VOLT);
        end
        else
        begin
            units_next = 2'd0;
            rem_wide   = hund2_reg;
        end

        tenth_prod  = TENTH_PROD_W'(rem3_reg) * TENTH_PROD_W'(TENTH_RECIP);
        tenths_next = tenth_prod[TENTH_SHIFT +: 4];

        tenth_back             = REM_W'(tenths4_reg) * REM_W'(DIGIT_BASE);
        digits_next.units      = units4_reg;
        digits_next.tenths     = tenths4_reg;
        digits_next.hundredths = 4'(rem4_reg - tenth_back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= start;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sel1_reg    <= sel;
        hprod1_reg  <= hprod_next;
        scaled1_reg <= scaled_next;
        sel2_reg    <= sel1_reg;
        hund2_reg   <= hund_next;
        sel3_reg    <= sel2_reg;
        units3_reg  <= units_next;
        rem3_reg    <= REM_W'(rem_wide);
        sel4_reg    <= sel3_reg;
        units4_reg  <= units3_reg;
        rem4_reg    <= rem3_reg;
        tenths4_reg <= tenths_next;
        sel5_reg    <= sel4_reg;
        digits5_reg <= digits_next;
    end

    assign result.valid  = valid5_reg;
    assign result.sel    = sel5_reg;
    assign result.digits = digits5_reg;

    a_conv_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 result.valid)
        else $error("Digit conversion did not finish five cycles after start.");

endmodule

`default_nettype wire

/* rtl/core/avm_datapath.sv */
// Datapath of the voltmeter: accumulator, mean division, min/max hold and display staging.
`default_nettype none

module avm_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire avm_pkg::meas_t       meas,
    input  wire avm_pkg::avm_cmd_t    cmd,
    output avm_pkg::avm_status_t      status,
    output avm_pkg::disp_t            disp
);
    import avm_pkg::*;

    logic [1:0]            func_reg;
    logic [CODE_W-1:0]     sample_reg;
    logic                  kind_reg, kind_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  sampling_on_reg, sampling_on_next;
    logic [CODE_W-1:0]     current_reg, current_next;
    logic [CODE_W-1:0]     last_reg, last_next;
    logic                  last_valid_reg, last_valid_next;
    logic [HOLD_W-1:0]     min_reg, min_next;
    logic [CODE_W-1:0]     max_reg, max_next;
    logic [DIV_PROD_W-1:0] div_prod_reg;
    digits_t               cur_dig_reg, min_dig_reg, max_dig_reg;
    disp_t                 disp_reg;

    logic [CNT_N_W-1:0]    cnt_inc;
    logic [SUM_W-1:0]      sum_add;
    logic [SUM_W-1:0]      q_est;
    logic [DIV_REM_W-1:0]  div_back;
    logic [DIV_REM_W-1:0]  div_rem;
    logic [SUM_W-1:0]      mean;
    logic [HOLD_W-1:0]     cur_ext;
    logic [HOLD_W-1:0]     conv_code;
    conv_out_t             conv_out;

    avm_digit_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.conv_start),
        .sel    (cmd.conv_sel),
        .code   (conv_code),
        .result (conv_out)
    );

    always_comb
    begin
        cnt_inc  = {1'b0, count_reg} + CNT_N_W'(1);
        sum_add  = sum_reg + SUM_W'(sample_reg);
        q_est    = div_prod_reg[DIV_SHIFT +: SUM_W];
        div_back = DIV_REM_W'(q_est) * DIV_REM_W'(CNT_N);
        div_rem  = DIV_REM_W'(sum_reg) - div_back;
        if (div_rem >= DIV_REM_W'(CNT_N))
        begin
            mean = q_est + SUM_W'(1);
        end
        else
        begin
            mean = q_est;
        end
        cur_ext = {1'b0, current_reg};

        unique case (cmd.conv_sel)
            SEL_CUR: conv_code = cur_ext;
            SEL_MIN: conv_code = min_reg;
            SEL_MAX: conv_code = {1'b0, max_reg};
            default: conv_code = cur_ext;
        endcase
    end

    always_comb
    begin
        kind_next        = kind_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        sampling_on_next = sampling_on_reg;
        current_next     = current_reg;
        last_next        = last_reg;
        last_valid_next  = last_valid_reg;
        min_next         = min_reg;
        max_next         = max_reg;

        if (cmd.exec)
        begin
            unique case (func_reg)
                FUNC_RESET_HOLD:
                begin
                    min_next  = cur_ext;
                    max_next  = current_reg;
                    kind_next = KIND_HOLD_RESET;
                end
                FUNC_TOGGLE:
                begin
                    sampling_on_next = !sampling_on_reg;
                end
                FUNC_SAMPLE:
                begin
                    if (sampling_on_reg)
                    begin
                        sum_next  = sum_add;
                        kind_next = KIND_READING;
                        if (cnt_inc < CNT_N)
                        begin
                            count_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.div_fix)
        begin
            current_next = mean[CODE_W-1:0];
            sum_next     = '0;
            count_next   = '0;
        end

        if (cmd.hold_upd)
        begin
            last_next       = current_reg;
            last_valid_next = 1'b1;
            priority if (min_reg > cur_ext)
            begin
                min_next = cur_ext;
            end
            else if (max_reg < current_reg)
            begin
                max_next = current_reg;
            end
            else if (min_reg == '0)
            begin
                min_next = cur_ext;
            end
            else if (max_reg == '0)
            begin
                max_next = current_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            count_reg       <= '0;
            sampling_on_reg <= 1'b0;
            current_reg     <= '0;
            last_reg        <= '0;
            last_valid_reg  <= 1'b0;
            min_reg         <= MIN_RESET;
            max_reg         <= '0;
        end
        else
        begin
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            sampling_on_reg <= sampling_on_next;
            current_reg     <= current_next;
            last_reg        <= last_next;
            last_valid_reg  <= last_valid_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        if (cmd.load_req)
        begin
            func_reg   <= meas.func;
            sample_reg <= meas.sample;
        end
        if (cmd.div_mul)
        begin
            div_prod_reg <= DIV_PROD_W'(sum_reg) * DIV_PROD_W'(DIV_RECIP);
        end
        if (conv_out.valid)
        begin
            unique case (conv_out.sel)
                SEL_CUR: cur_dig_reg <= conv_out.digits;
                SEL_MIN: min_dig_reg <= conv_out.digits;
                SEL_MAX: max_dig_reg <= conv_out.digits;
                default:
                begin
                end
            endcase
        end
        if (cmd.emit_load)
        begin
            disp_reg.kind           <= kind_reg;
            disp_reg.cur_units      <= cur_dig_reg.units;
            disp_reg.cur_tenths     <= cur_dig_reg.tenths;
            disp_reg.cur_hundredths <= cur_dig_reg.hundredths;
            disp_reg.min_units      <= min_dig_reg.units;
            disp_reg.min_tenths     <= min_dig_reg.tenths;
            disp_reg.min_hundredths <= min_dig_reg.hundredths;
            disp_reg.max_units      <= max_dig_reg.units;
            disp_reg.max_tenths     <= max_dig_reg.tenths;
            disp_reg.max_hundredths <= max_dig_reg.hundredths;
        end
    end

    assign status.func         = func_reg;
    assign status.sampling_on  = sampling_on_reg;
    assign status.avg_complete = (cnt_inc >= CNT_N);
    assign status.mean_repeat  = last_valid_reg && (last_reg == current_reg);
    assign status.conv_done    = conv_out.valid && (conv_out.sel == SEL_MAX);
    assign disp                = disp_reg;

    a_count_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < CNT_N)
        else $error("Sample count reached the averaging length.");

    a_hold_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hold_upd |=> (last_valid_reg && (last_reg == current_reg)))
        else $error("Hold update did not record the new mean.");

endmodule

`default_nettype wire

/* rtl/core/avm_ctrl.sv */
// Controller state machine that sequences each request through the voltmeter datapath.
`default_nettype none

module avm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  meas_valid,
    output logic                       meas_stall,
    input  wire avm_pkg::avm_status_t  status,
    output avm_pkg::avm_cmd_t          cmd,
    output logic                       disp_valid,
    input  wire logic                  disp_stall
);
    import avm_pkg::*;

    avm_state_t state_reg, state_next;
    logic       disp_valid_reg, disp_valid_next;
    logic       disp_free;

    assign disp_free = !disp_valid_reg || !disp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.conv_sel = SEL_CUR;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if (status.func == FUNC_RESET_HOLD)
                begin
                    state_next = ST_CONV_CUR;
                end
                else if ((status.func == FUNC_SAMPLE) && status.sampling_on
                         && status.avg_complete)
                begin
                    state_next = ST_DIV_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_MUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (status.mean_repeat)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.hold_upd = 1'b1;
                    state_next   = ST_CONV_CUR;
                end
            end
            ST_CONV_CUR:
            begin
                cmd.conv_start = 1'b1;
                cmd.conv_sel   = SEL_CUR;
                state_next     = ST_CONV_MIN;
            end
            ST_CONV_MIN:
            begin
                cmd.conv_start = 1'b1;
                cmd.conv_sel   = SEL_MIN;
                state_next     = ST_CONV_MAX;
            end
            ST_CONV_MAX:
            begin
                cmd.conv_start = 1'b1;
                cmd.conv_sel   = SEL_MAX;
                state_next     = ST_CONV_WAIT;
            end
            ST_CONV_WAIT:
            begin
                if (status.conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (disp_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit_load)
        begin
            disp_valid_next = 1'b1;
        end
        else if (!disp_stall)
        begin
            disp_valid_next = 1'b0;
        end
        else
        begin
            disp_valid_next = disp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            disp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            disp_valid_reg <= disp_valid_next;
        end
    end

    assign meas_stall = (state_reg != ST_IDLE);
    assign disp_valid = disp_valid_reg;

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (!disp_valid_reg || !disp_stall))
        else $error("Display register overwritten while a result was pending.");

    a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (meas_valid && !meas_stall) |=> (state_reg == ST_EXEC))
        else $error("Accepted request did not move to execution.");

    a_emit_raises_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> disp_valid)
        else $error("Loaded result was not presented.");

endmodule

`default_nettype wire

/* rtl/core/averaging_voltmeter_min_max_core.sv */
// Top level of the averaging voltmeter with min/max hold.
//
// Requests arrive on meas (func and sample) under meas_valid/meas_stall; a
// request is taken at a clock edge where meas_valid is high and meas_stall is
// low. Results leave on disp under disp_valid/disp_stall as volt, tenth and
// hundredth digits of the current reading, the held minimum and the maximum.
// The block works on one request at a time, sequenced by a state machine.
// A sample that does not complete an average, a toggle key and an ignored
// request each pass through the execute state only. A completed average runs
// one multiply stage and one correction stage for the mean; if the mean repeats
// the last one it ends there with no result, else a hold update follows, then
// three codes through the five-stage digit pipeline. A min/max reset key skips
// the mean and sends its three codes straight through the digit pipeline.
// A finished result waits in the display register while the next request is
// taken; if disp_stall is still high when another result is ready, the block
// holds that result and stalls new requests until the register frees up.
// Reset clears the sum, count and hold, turns sampling off, sets the minimum
// above full scale and drops disp_valid.
`default_nettype none

module averaging_voltmeter_min_max_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            meas_valid,
    output logic                 meas_stall,
    input  wire avm_pkg::meas_t  meas,
    output logic                 disp_valid,
    input  wire logic            disp_stall,
    output avm_pkg::disp_t       disp
);
    import avm_pkg::*;

    avm_cmd_t    cmd;
    avm_status_t status;

    avm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .status     (status),
        .cmd        (cmd),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall)
    );

    avm_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .meas   (meas),
        .cmd    (cmd),
        .status (status),
        .disp   (disp)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the averaging voltmeter core with a directed table and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import avm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REQUESTS = 800;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] sample;
        logic [4:0]  reps;
        logic        typed;
        disp_t       shown;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic meas_valid = 1'b0;
    logic meas_stall;
    meas_t meas = '0;
    logic disp_valid;
    logic disp_stall = 1'b0;
    disp_t disp;

    int idle_pct = 19;
    int stall_pct = 67;
    bit hold_display = 1'b0;
    int error_count = 0;
    int quiet_cycles = 0;

    disp_t pending_displays[$];
    script_row_t script[$];

    logic [15:0] reading_sum = '0;
    logic [3:0]  reading_count = '0;
    logic        sampling_en = 1'b0;
    logic [11:0] cur_code = '0;
    logic [11:0] prev_mean = '0;
    logic        prev_valid = 1'b0;
    logic [12:0] hold_min = MIN_RESET;
    logic [11:0] hold_max = '0;
    logic [11:0] level = '0;

    averaging_voltmeter_min_max_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .meas       (meas),
        .disp_valid (disp_valid),
        .disp_stall (disp_stall),
        .disp       (disp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [9:0] volts_digits(input int h);
        logic [1:0] units;
        logic [3:0] tenths;
        logic [3:0] hundredths;
        units = 2'(h / 100);
        tenths = 4'((h / 10) % 10);
        hundredths = 4'(h % 10);
        return {units, tenths, hundredths};
    endfunction

    function automatic disp_t make_disp(input logic kind, input int hc, input int hm,
                                        input int hx);
        return disp_t'({kind, volts_digits(hc), volts_digits(hm), volts_digits(hx)});
    endfunction

    function automatic int hundredths_of(input logic [12:0] code);
        return (int'(code) * SCALE_HUNDREDTHS) / FULL_SCALE;
    endfunction

    function automatic disp_t shown_reading(input logic kind);
        return make_disp(kind, hundredths_of({1'b0, cur_code}), hundredths_of(hold_min),
                         hundredths_of({1'b0, hold_max}));
    endfunction

    task automatic predict_display(input meas_t m, output bit acted, output bit has_result,
                                   output disp_t r);
        logic [11:0] mean;
        acted = 1'b1;
        has_result = 1'b0;
        r = '0;
        case (m.func)
            FUNC_RESET_HOLD:
            begin
                hold_min = {1'b0, cur_code};
                hold_max = cur_code;
                has_result = 1'b1;
                r = shown_reading(KIND_HOLD_RESET);
            end
            FUNC_TOGGLE:
            begin
                sampling_en = !sampling_en;
            end
            FUNC_SAMPLE:
            begin
                if (!sampling_en)
                begin
                    acted = 1'b0;
                end
                else
                begin
                    reading_sum = reading_sum + 16'(m.sample);
                    if (int'(reading_count) + 1 < AVG_N)
                    begin
                        reading_count = reading_count + 4'd1;
                    end
                    else
                    begin
                        mean = 12'(int'(reading_sum) / AVG_N);
                        reading_sum = '0;
                        reading_count = '0;
                        cur_code = mean;
                        if (!(prev_valid && prev_mean == mean))
                        begin
                            prev_mean = mean;
                            prev_valid = 1'b1;
                            if (hold_min > {1'b0, mean})
                                hold_min = {1'b0, mean};
                            else if (hold_max < mean)
                                hold_max = mean;
                            else if (hold_min == '0)
                                hold_min = {1'b0, mean};
                            else if (hold_max == '0)
                                hold_max = mean;
                            has_result = 1'b1;
                            r = shown_reading(KIND_READING);
                        end
                    end
                end
            end
            default:
            begin
                acted = 1'b0;
            end
        endcase
    endtask

    task automatic issue_request(input meas_t m, input bit typed, input disp_t shown,
                                 output bit acted);
        bit has_result;
        disp_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            meas_valid <= 1'b0;
            @(posedge clk);
        end
        meas_valid <= 1'b1;
        meas <= m;
        @(posedge clk);
        while (meas_stall)
            @(posedge clk);
        predict_display(m, acted, has_result, predicted);
        if (typed)
            pending_displays.push_back(shown);
        else if (has_result)
            pending_displays.push_back(predicted);
    endtask

    task automatic add_row(input logic [1:0] func, input logic [11:0] sample,
                           input int reps, input bit typed, input disp_t shown);
        script_row_t row;
        row.func = func;
        row.sample = sample;
        row.reps = 5'(reps);
        row.typed = typed;
        row.shown = shown;
        script.push_back(row);
    endtask

    task automatic run_random(input int budget);
        int done;
        int pick;
        int n;
        int pat;
        bit acted;
        meas_t m;
        done = 0;
        while (done < budget)
        begin
            pick = $urandom_range(99);
            if (!sampling_en && pick < 85)
            begin
                m.func = FUNC_TOGGLE;
                m.sample = 12'($urandom_range(4095));
                issue_request(m, 1'b0, '0, acted);
                done += int'(acted);
            end
            else if (pick < 70)
            begin
                if ($urandom_range(3) == 0)
                    level = 12'($urandom_range(4095));
                pat = $urandom_range(3);
                if ($urandom_range(9) < 7)
                    n = AVG_N - int'(reading_count);
                else
                    n = $urandom_range(AVG_N, 1);
                repeat (n)
                begin
                    m.func = FUNC_SAMPLE;
                    case (pat)
                        0: m.sample = level;
                        1: m.sample = 12'($urandom_range(4095));
                        2: m.sample = level + 12'($urandom_range(6)) - 12'd3;
                        default: m.sample = $urandom_range(1) ? 12'hFFF : 12'h000;
                    endcase
                    issue_request(m, 1'b0, '0, acted);
                    done += int'(acted);
                end
            end
            else if (pick < 80)
            begin
                m.func = FUNC_RESET_HOLD;
                m.sample = 12'($urandom_range(4095));
                issue_request(m, 1'b0, '0, acted);
                done += int'(acted);
            end
            else if (pick < 86)
            begin
                m.func = FUNC_TOGGLE;
                m.sample = 12'($urandom_range(4095));
                issue_request(m, 1'b0, '0, acted);
                done += int'(acted);
            end
            else
            begin
                m.func = 2'($urandom_range(3));
                m.sample = 12'($urandom_range(4095));
                issue_request(m, 1'b0, '0, acted);
                done += int'(acted);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_display)
            begin
                disp_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_display = 1'b0;
            end
            disp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : display_check
        disp_t want;
        if (rst_n && disp_valid && !disp_stall)
        begin
            if (pending_displays.size() == 0)
            begin
                $error("display result with no request pending");
                error_count++;
            end
            else
            begin
                want = pending_displays.pop_front();
                check_field("kind", want.kind, disp.kind);
                check_field("cur_units", want.cur_units, disp.cur_units);
                check_field("cur_tenths", want.cur_tenths, disp.cur_tenths);
                check_field("cur_hundredths", want.cur_hundredths, disp.cur_hundredths);
                check_field("min_units", want.min_units, disp.min_units);
                check_field("min_tenths", want.min_tenths, disp.min_tenths);
                check_field("min_hundredths", want.min_hundredths, disp.min_hundredths);
                check_field("max_units", want.max_units, disp.max_units);
                check_field("max_tenths", want.max_tenths, disp.max_tenths);
                check_field("max_hundredths", want.max_hundredths, disp.max_hundredths);
            end
        end
        if (!rst_n || (meas_valid && !meas_stall) || (disp_valid && !disp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        meas_t m;
        bit acted;
        add_row(FUNC_RESET_HOLD, 12'h000, 1, 1'b1, make_disp(KIND_HOLD_RESET, 0, 0, 0));
        add_row(FUNC_SAMPLE, 12'hFFF, 1, 1'b0, '0);
        add_row(FUNC_UNUSED, 12'hABC, 1, 1'b0, '0);
        add_row(FUNC_TOGGLE, 12'hFFF, 1, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'hFFF, AVG_N, 1'b1, make_disp(KIND_READING, 250, 0, 250));
        add_row(FUNC_SAMPLE, 12'h000, 4, 1'b0, '0);
        add_row(FUNC_TOGGLE, 12'h000, 1, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h555, 1, 1'b0, '0);
        add_row(FUNC_TOGGLE, 12'h000, 1, 1'b0, '0);
        add_row(FUNC_SAMPLE, 12'h000, AVG_N - 4, 1'b1, make_disp(KIND_READING, 0, 0, 250));
        add_row(FUNC_RESET_HOLD, 12'hAAA, 1, 1'b1, make_disp(KIND_HOLD_RESET, 0, 0, 0));

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            for (int k = 0; k < int'(script[i].reps); k++)
            begin
                m.func = script[i].func;
                m.sample = script[i].sample;
                issue_request(m, script[i].typed && (k == int'(script[i].reps) - 1),
                              script[i].shown, acted);
            end
        end

        run_random(RANDOM_REQUESTS / 3);

        idle_pct = 67;
        stall_pct = 19;
        run_random(RANDOM_REQUESTS / 3);

        // The display side holds off while reset-key requests keep coming, so the core backs up.
        idle_pct = 0;
        stall_pct = 0;
        hold_display = 1'b1;
        repeat (8)
        begin
            m.func = FUNC_RESET_HOLD;
            m.sample = 12'($urandom_range(4095));
            issue_request(m, 1'b0, '0, acted);
        end
        run_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3) - 8);

        meas_valid <= 1'b0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/avm_pkg.sv
rtl/core/avm_digit_conv.sv
rtl/core/avm_datapath.sv
rtl/core/avm_ctrl.sv
rtl/core/averaging_voltmeter_min_max_core.sv
test/testbench.sv
